/* rtl/gpp_pkg.sv */
package gpp_pkg;

    localparam int POS_BITS      = 24;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int STG_W         = $clog2(MAX_STAGES);
    localparam int EXT           = 34 - POS_BITS;
    localparam int VEC_W         = 37;
    localparam int TRIG_W        = 30;
    localparam int TZ_W          = 34;
    localparam int VX_W          = 60;
    localparam int PH_W          = 32;
    localparam int TRIG_FRAC     = 26;
    localparam int VEC_SHIFT     = 20;
    localparam int GAIN20_W      = 21;
    localparam int MPROD_W       = VX_W - VEC_SHIFT + GAIN20_W;

    localparam logic [PH_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [PH_W-1:0] CODE_HALF    = PH_W'(2**(31 - ANGLE_BITS));

    typedef logic signed [POS_BITS-1:0]   t_pos;
    typedef logic signed [ANGLE_BITS-1:0] t_ang;
    typedef logic signed [VEC_W-1:0]      t_comp;
    typedef logic signed [TRIG_W-1:0]     t_trig;
    typedef logic signed [TZ_W-1:0]       t_tz;
    typedef logic signed [VX_W-1:0]       t_vx;

    localparam t_trig GAIN_Q26 = TRIG_W'(40752055);
    localparam logic signed [GAIN20_W-1:0] GAIN_Q20 = GAIN20_W'(636751);

    typedef enum logic [2:0] {
        MODE_PITCH      = 3'd0,
        MODE_ROLL       = 3'd1,
        MODE_NOSE_PAN   = 3'd2,
        MODE_NOSE_FOLD  = 3'd3,
        MODE_SIDE       = 3'd4,
        MODE_PITCH_ROLL = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        AXIS_YAW   = 2'd0,
        AXIS_PITCH = 2'd1,
        AXIS_ROLL  = 2'd2
    } t_axis;

    typedef struct packed {
        logic [2:0]      mode;
        t_comp           x;
        t_comp           y;
        t_comp           z;
        logic [2:0]      flip;
        t_trig           yaw_c;
        t_trig           yaw_s;
        t_trig           pitch_c;
        t_trig           pitch_s;
        t_trig           roll_c;
        t_trig           roll_s;
        logic            neg;
        logic            zero1;
        logic            zero2;
        logic            zero3;
        logic [PH_W-1:0] ang2;
        t_comp           mag;
    } t_carry;

    typedef struct packed {
        t_vx             x;
        t_vx             y;
        logic [PH_W-1:0] z;
        logic            zero;
    } t_vin;

    typedef struct packed {
        logic flip;
        t_tz  z;
    } t_rin;

    function automatic logic [PH_W-1:0] f_atan(input logic [STG_W-1:0] idx);
        logic [PH_W-1:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_comp f_diff(input t_pos a, input t_pos b);
        logic signed [POS_BITS:0] d;
        d = {a[POS_BITS-1], a} - {b[POS_BITS-1], b};
        return t_comp'(d) <<< EXT;
    endfunction

    function automatic t_rin f_rot_prep(input logic [ANGLE_BITS-1:0] ang);
        t_rin            r;
        logic [PH_W-1:0] ph;
        logic [PH_W-1:0] t;
        ph = {ang, {(PH_W - ANGLE_BITS){1'b0}}};
        t = ph + QUARTER_TURN;
        r.flip = t[PH_W-1];
        if (r.flip) begin
            ph = ph + HALF_TURN;
        end
        r.z = t_tz'(signed'(ph));
        return r;
    endfunction

    function automatic t_vin f_vec_prep(input t_comp xi, input t_comp yi);
        t_vin r;
        t_vx  xe;
        t_vx  ye;
        xe = t_vx'(xi);
        ye = t_vx'(yi);
        r.zero = (xi == '0) && (yi == '0);
        r.z = '0;
        if (xi[VEC_W-1]) begin
            xe = -xe;
            ye = -ye;
            r.z = HALF_TURN;
        end
        r.x = xe <<< VEC_SHIFT;
        r.y = ye <<< VEC_SHIFT;
        return r;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] f_code(input logic [PH_W-1:0] ph);
        logic [PH_W-1:0] t;
        t = ph + CODE_HALF;
        return t[PH_W-1:PH_W-ANGLE_BITS];
    endfunction

endpackage

/* rtl/gpp_in_if.sv */
interface gpp_in_if import gpp_pkg::*; ();
    logic valid;
    logic ready;
    t_pos plane_east;
    t_pos plane_north;
    t_pos plane_alt;
    t_ang roll_angle;
    t_ang pitch_angle;
    t_ang yaw_angle;
    t_pos target_east;
    t_pos target_north;
    t_pos target_alt;

    modport source (
        output valid, plane_east, plane_north, plane_alt, roll_angle, pitch_angle,
               yaw_angle, target_east, target_north, target_alt,
        input  ready
    );
    modport sink (
        input  valid, plane_east, plane_north, plane_alt, roll_angle, pitch_angle,
               yaw_angle, target_east, target_north, target_alt,
        output ready
    );
endinterface

/* rtl/gpp_out_if.sv */
interface gpp_out_if import gpp_pkg::*; ();
    logic valid;
    logic ready;
    t_ang pan_angle;
    t_ang tilt_angle;

    modport source (output valid, pan_angle, tilt_angle, input ready);
    modport sink (input valid, pan_angle, tilt_angle, output ready);
endinterface

/* rtl/gpp_rot_cell.sv */
module gpp_rot_cell import gpp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [STG_W-1:0] i_stage,
    input  t_trig            i_x,
    input  t_trig            i_y,
    input  t_tz              i_z,
    output t_trig            o_x,
    output t_trig            o_y,
    output t_tz              o_z
);
    t_trig r_x, r_y, n_x, n_y;
    t_tz   r_z, n_z, w_atan;

    always_comb begin
        w_atan = t_tz'(f_atan(i_stage));
        if (!i_z[TZ_W-1]) begin
            n_x = i_x - (i_y >>> i_stage);
            n_y = i_y + (i_x >>> i_stage);
            n_z = i_z - w_atan;
        end else begin
            n_x = i_x + (i_y >>> i_stage);
            n_y = i_y - (i_x >>> i_stage);
            n_z = i_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

/* rtl/gpp_vec_cell.sv */
module gpp_vec_cell import gpp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [STG_W-1:0] i_stage,
    input  t_vx              i_x,
    input  t_vx              i_y,
    input  logic [PH_W-1:0]  i_z,
    output t_vx              o_x,
    output t_vx              o_y,
    output logic [PH_W-1:0]  o_z
);
    t_vx             r_x, r_y, n_x, n_y;
    logic [PH_W-1:0] r_z, n_z;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> i_stage);
            n_y = i_y - (i_x >>> i_stage);
            n_z = i_z + f_atan(i_stage);
        end else begin
            n_x = i_x - (i_y >>> i_stage);
            n_y = i_y + (i_x >>> i_stage);
            n_z = i_z - f_atan(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

/* rtl/gpp_rotate.sv */
module gpp_rotate import gpp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_axis  i_axis,
    input  t_carry i_carry,
    output t_carry o_carry
);
    localparam int LO_W  = 18;
    localparam int HI_W  = VEC_W - LO_W;
    localparam int PP_W  = TRIG_W + HI_W;
    localparam int SUM_W = TRIG_W + VEC_W + 2;
    localparam logic signed [SUM_W-1:0] ROT_HALF = SUM_W'(2**(TRIG_FRAC - 1));

    t_trig                  w_c, w_s;
    t_comp                  w_a, w_b;
    logic signed [HI_W-1:0] w_ah, w_al, w_bh, w_bl;
    logic signed [PP_W-1:0] r_p [8];
    logic signed [PP_W-1:0] n_p [8];
    logic signed [SUM_W-1:0] w_t1, w_t2;
    t_comp                  w_n1, w_n2;
    t_carry                 r_c1, r_c2, n_c2;

    always_comb begin
        case (i_axis)
            AXIS_PITCH: begin
                w_c = i_carry.pitch_c;
                w_s = i_carry.pitch_s;
                w_a = i_carry.x;
                w_b = i_carry.z;
            end
            AXIS_ROLL: begin
                w_c = i_carry.roll_c;
                w_s = i_carry.roll_s;
                w_a = i_carry.z;
                w_b = i_carry.y;
            end
            default: begin
                w_c = i_carry.yaw_c;
                w_s = i_carry.yaw_s;
                w_a = i_carry.x;
                w_b = i_carry.y;
            end
        endcase
        w_ah = w_a[VEC_W-1:LO_W];
        w_al = {{(HI_W - LO_W){1'b0}}, w_a[LO_W-1:0]};
        w_bh = w_b[VEC_W-1:LO_W];
        w_bl = {{(HI_W - LO_W){1'b0}}, w_b[LO_W-1:0]};
        n_p[0] = w_c * w_ah;
        n_p[1] = w_c * w_al;
        n_p[2] = w_s * w_bh;
        n_p[3] = w_s * w_bl;
        n_p[4] = w_c * w_bh;
        n_p[5] = w_c * w_bl;
        n_p[6] = w_s * w_ah;
        n_p[7] = w_s * w_al;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_c1 <= i_carry;
            r_c2 <= n_c2;
        end
    end

    always_comb begin
        w_t1 = (SUM_W'(r_p[0]) <<< LO_W) + SUM_W'(r_p[1])
             + (SUM_W'(r_p[2]) <<< LO_W) + SUM_W'(r_p[3]) + ROT_HALF;
        w_t2 = (SUM_W'(r_p[4]) <<< LO_W) + SUM_W'(r_p[5])
             - (SUM_W'(r_p[6]) <<< LO_W) - SUM_W'(r_p[7]) + ROT_HALF;
        w_n1 = t_comp'(w_t1 >>> TRIG_FRAC);
        w_n2 = t_comp'(w_t2 >>> TRIG_FRAC);
        n_c2 = r_c1;
        case (i_axis)
            AXIS_PITCH: begin
                n_c2.x = w_n1;
                n_c2.z = w_n2;
            end
            AXIS_ROLL: begin
                n_c2.z = w_n1;
                n_c2.y = w_n2;
            end
            default: begin
                n_c2.x = w_n1;
                n_c2.y = w_n2;
            end
        endcase
    end

    assign o_carry = r_c2;
endmodule

/* rtl/gimbal_pan_tilt_pointing.sv */
// Pan/tilt pointing toward a ground target. Takes one word per clock while
// input ready is high and returns one word per input, in order. The pipeline
// holds three CORDIC cell chains in series: the sine/cosine chain for yaw,
// pitch and roll, the magnitude/angle chain and the final angle chain. An
// output register with a one-word skid buffer absorbs one result while the
// output stalls; input ready drops only while the skid word is held.
// mount_mode is sampled per word at input and should be written only while
// the block is empty.
module gimbal_pan_tilt_pointing import gpp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gpp_in_if.sink           i_in,
    gpp_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_data
);
    localparam int S   = CORDIC_STAGES;
    localparam int LAT = 3 * CORDIC_STAGES + 16;
    localparam logic signed [MPROD_W-1:0] MAG_HALF = MPROD_W'(2**(VEC_SHIFT - 1));

    logic                  w_en;
    logic [2:0]            r_mode;
    logic [LAT-1:0]        r_vld;

    t_carry                r_c0, n_c0;
    t_tz                   r_z0 [3];
    t_rin                  w_ry, w_rp, w_rr;
    t_carry                r_rs [S];
    t_trig                 w_rx [3][S+1];
    t_trig                 w_ry_c [3][S+1];
    t_tz                   w_rz [3][S+1];
    t_carry                r_cf, n_cf;
    t_carry                w_cy, w_cp, w_cr;

    t_carry                r_p1, n_p1;
    t_comp                 r_v1x, r_v1y, r_v2x, r_v2y, n_v1x, n_v1y, n_v2x, n_v2y;
    t_carry                r_p2, n_p2;
    t_vin                  r_a0, r_b0, n_a0, n_b0;
    t_vx                   w_ax [S+1];
    t_vx                   w_ay [S+1];
    logic [PH_W-1:0]       w_az [S+1];
    t_vx                   w_bx [S+1];
    t_vx                   w_by [S+1];
    logic [PH_W-1:0]       w_bz [S+1];
    t_carry                r_vs1 [S];

    t_carry                r_m1, n_m1, r_m2, n_m2;
    logic signed [VX_W-VEC_SHIFT-1:0] w_msh;
    logic signed [MPROD_W-1:0]        r_prod, n_prod;

    t_carry                r_q1, n_q1, r_q2, n_q2;
    t_comp                 r_v3x, r_v3y, n_v3x, n_v3y;
    t_vin                  r_c3, n_c3;
    t_vx                   w_cx [S+1];
    t_vx                   w_cyv [S+1];
    logic [PH_W-1:0]       w_cz [S+1];
    t_carry                r_vs3 [S];

    t_carry                r_k1;
    logic [ANGLE_BITS-1:0] r_code2, r_code3;
    logic [ANGLE_BITS-1:0] r_pan, r_tilt, n_pan, n_tilt;

    logic                  r_out_valid, r_sk_valid;
    logic [ANGLE_BITS-1:0] r_out_pan, r_out_tilt, r_sk_pan, r_sk_tilt;

    assign w_en       = !r_sk_valid;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SIDE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // input stage: difference vector and sine/cosine phase setup
    always_comb begin
        w_ry = f_rot_prep(i_in.yaw_angle);
        w_rp = f_rot_prep(i_in.pitch_angle);
        w_rr = f_rot_prep(i_in.roll_angle);
        n_c0 = '0;
        n_c0.mode = r_mode;
        n_c0.x = f_diff(i_in.target_north, i_in.plane_north);
        n_c0.y = f_diff(i_in.target_east, i_in.plane_east);
        n_c0.z = f_diff(i_in.target_alt, i_in.plane_alt);
        n_c0.flip[AXIS_YAW]   = w_ry.flip;
        n_c0.flip[AXIS_PITCH] = w_rp.flip;
        n_c0.flip[AXIS_ROLL]  = w_rr.flip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0    <= n_c0;
            r_z0[0] <= w_ry.z;
            r_z0[1] <= w_rp.z;
            r_z0[2] <= w_rr.z;
            r_rs[0] <= r_c0;
            for (int k = 1; k < S; k++) begin
                r_rs[k] <= r_rs[k-1];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_sincos
        assign w_rx[a][0]   = GAIN_Q26;
        assign w_ry_c[a][0] = '0;
        assign w_rz[a][0]   = r_z0[a];
        for (genvar k = 0; k < S; k++) begin : g_cell
            gpp_rot_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_stage (STG_W'(k)),
                .i_x     (w_rx[a][k]),
                .i_y     (w_ry_c[a][k]),
                .i_z     (w_rz[a][k]),
                .o_x     (w_rx[a][k+1]),
                .o_y     (w_ry_c[a][k+1]),
                .o_z     (w_rz[a][k+1])
            );
        end
    end

    always_comb begin
        n_cf = r_rs[S-1];
        n_cf.yaw_c   = n_cf.flip[AXIS_YAW]   ? -w_rx[0][S]   : w_rx[0][S];
        n_cf.yaw_s   = n_cf.flip[AXIS_YAW]   ? -w_ry_c[0][S] : w_ry_c[0][S];
        n_cf.pitch_c = n_cf.flip[AXIS_PITCH] ? -w_rx[1][S]   : w_rx[1][S];
        n_cf.pitch_s = n_cf.flip[AXIS_PITCH] ? -w_ry_c[1][S] : w_ry_c[1][S];
        n_cf.roll_c  = n_cf.flip[AXIS_ROLL]  ? -w_rx[2][S]   : w_rx[2][S];
        n_cf.roll_s  = n_cf.flip[AXIS_ROLL]  ? -w_ry_c[2][S] : w_ry_c[2][S];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cf <= n_cf;
        end
    end

    gpp_rotate u_yaw (
        .i_clk (i_clk), .i_en (w_en), .i_axis (AXIS_YAW), .i_carry (r_cf), .o_carry (w_cy)
    );
    gpp_rotate u_pitch (
        .i_clk (i_clk), .i_en (w_en), .i_axis (AXIS_PITCH), .i_carry (w_cy), .o_carry (w_cp)
    );
    gpp_rotate u_roll (
        .i_clk (i_clk), .i_en (w_en), .i_axis (AXIS_ROLL), .i_carry (w_cp), .o_carry (w_cr)
    );

    // select operands of the magnitude chain and the first angle chain
    always_comb begin
        n_p1 = w_cr;
        n_p1.neg = 1'b0;
        n_v1x = w_cr.x;
        n_v1y = w_cr.y;
        n_v2x = w_cr.x;
        n_v2y = w_cr.y;
        case (t_mode'(w_cr.mode))
            MODE_PITCH: begin
                n_v2x = -w_cr.z;
                n_v2y = w_cr.x;
            end
            MODE_ROLL: begin
                n_v1y = w_cr.z;
            end
            MODE_NOSE_PAN: begin
            end
            MODE_NOSE_FOLD: begin
                n_p1.neg = w_cr.x[VEC_W-1];
                n_v2x = w_cr.x[VEC_W-1] ? -w_cr.x : w_cr.x;
            end
            MODE_SIDE: begin
                n_p1.neg = w_cr.y[VEC_W-1];
                n_v2x = w_cr.y[VEC_W-1] ? -w_cr.y : w_cr.y;
                n_v2y = w_cr.x;
            end
            MODE_PITCH_ROLL: begin
                n_v1y = w_cr.z;
                n_v2x = -w_cr.z;
                n_v2y = w_cr.x;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_a0 = f_vec_prep(r_v1x, r_v1y);
        n_b0 = f_vec_prep(r_v2x, r_v2y);
        n_p2 = r_p1;
        n_p2.zero1 = n_a0.zero;
        n_p2.zero2 = n_b0.zero;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1     <= n_p1;
            r_v1x    <= n_v1x;
            r_v1y    <= n_v1y;
            r_v2x    <= n_v2x;
            r_v2y    <= n_v2y;
            r_p2     <= n_p2;
            r_a0     <= n_a0;
            r_b0     <= n_b0;
            r_vs1[0] <= r_p2;
            for (int k = 1; k < S; k++) begin
                r_vs1[k] <= r_vs1[k-1];
            end
        end
    end

    assign w_ax[0] = r_a0.x;
    assign w_ay[0] = r_a0.y;
    assign w_az[0] = r_a0.z;
    assign w_bx[0] = r_b0.x;
    assign w_by[0] = r_b0.y;
    assign w_bz[0] = r_b0.z;

    for (genvar k = 0; k < S; k++) begin : g_vec1
        gpp_vec_cell u_mag (
            .i_clk (i_clk), .i_en (w_en), .i_stage (STG_W'(k)),
            .i_x (w_ax[k]), .i_y (w_ay[k]), .i_z (w_az[k]),
            .o_x (w_ax[k+1]), .o_y (w_ay[k+1]), .o_z (w_az[k+1])
        );
        gpp_vec_cell u_ang (
            .i_clk (i_clk), .i_en (w_en), .i_stage (STG_W'(k)),
            .i_x (w_bx[k]), .i_y (w_by[k]), .i_z (w_bz[k]),
            .o_x (w_bx[k+1]), .o_y (w_by[k+1]), .o_z (w_bz[k+1])
        );
    end

    // magnitude: drop the guard bits, scale by the CORDIC gain, round
    always_comb begin
        w_msh  = w_ax[S][VX_W-1:VEC_SHIFT];
        n_prod = w_msh * GAIN_Q20;
        n_m1 = r_vs1[S-1];
        n_m1.ang2 = w_bz[S];
        n_m2 = r_m1;
        n_m2.mag = r_m1.zero1 ? '0 : t_comp'((r_prod + MAG_HALF) >>> VEC_SHIFT);
    end

    always_comb begin
        n_q1 = r_m2;
        case (t_mode'(r_m2.mode))
            MODE_ROLL: begin
                n_v3x = r_m2.mag;
                n_v3y = r_m2.y;
            end
            MODE_PITCH_ROLL: begin
                n_v3x = r_m2.mag;
                n_v3y = -r_m2.y;
            end
            default: begin
                n_v3x = -r_m2.z;
                n_v3y = r_m2.mag;
            end
        endcase
        n_c3 = f_vec_prep(r_v3x, r_v3y);
        n_q2 = r_q1;
        n_q2.zero3 = n_c3.zero;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1     <= n_m1;
            r_prod   <= n_prod;
            r_m2     <= n_m2;
            r_q1     <= n_q1;
            r_v3x    <= n_v3x;
            r_v3y    <= n_v3y;
            r_q2     <= n_q2;
            r_c3     <= n_c3;
            r_vs3[0] <= r_q2;
            for (int k = 1; k < S; k++) begin
                r_vs3[k] <= r_vs3[k-1];
            end
        end
    end

    assign w_cx[0]  = r_c3.x;
    assign w_cyv[0] = r_c3.y;
    assign w_cz[0]  = r_c3.z;

    for (genvar k = 0; k < S; k++) begin : g_vec3
        gpp_vec_cell u_ang (
            .i_clk (i_clk), .i_en (w_en), .i_stage (STG_W'(k)),
            .i_x (w_cx[k]), .i_y (w_cyv[k]), .i_z (w_cz[k]),
            .o_x (w_cx[k+1]), .o_y (w_cyv[k+1]), .o_z (w_cz[k+1])
        );
    end

    // map the two angle codes onto pan and tilt
    always_comb begin
        n_pan  = '0;
        n_tilt = '0;
        case (t_mode'(r_k1.mode))
            MODE_PITCH: begin
                n_tilt = r_code2;
            end
            MODE_ROLL: begin
                n_tilt = r_code3;
            end
            MODE_NOSE_PAN: begin
                n_pan  = r_code2;
                n_tilt = r_code3;
            end
            MODE_NOSE_FOLD, MODE_SIDE: begin
                n_pan  = r_k1.neg ? -r_code2 : r_code2;
                n_tilt = r_k1.neg ? -r_code3 : r_code3;
            end
            MODE_PITCH_ROLL: begin
                n_pan  = r_code3;
                n_tilt = r_code2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k1    <= r_vs3[S-1];
            r_code2 <= f_code(r_vs3[S-1].zero2 ? '0 : r_vs3[S-1].ang2);
            r_code3 <= f_code(r_vs3[S-1].zero3 ? '0 : w_cz[S]);
            r_pan   <= n_pan;
            r_tilt  <= n_tilt;
        end
    end

    // output register and skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= r_vld[LAT-1];
            end
        end else if (r_vld[LAT-1] && !r_sk_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            if (r_sk_valid) begin
                r_out_pan  <= r_sk_pan;
                r_out_tilt <= r_sk_tilt;
            end else begin
                r_out_pan  <= r_pan;
                r_out_tilt <= r_tilt;
            end
        end else if (!r_sk_valid) begin
            r_sk_pan  <= r_pan;
            r_sk_tilt <= r_tilt;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pan_angle  = r_out_pan;
    assign o_out.tilt_angle = r_out_tilt;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid word held while output register empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_out_valid && !o_out.ready))
        else $error("skid word filled without an output stall");

    a_single_axis_pan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && (r_k1.mode == MODE_PITCH || r_k1.mode == MODE_ROLL)) |=> (r_pan == '0))
        else $error("pan nonzero in a single-axis mode");

    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && (r_k1.mode == 3'd6 || r_k1.mode == 3'd7))
        |=> (r_pan == '0 && r_tilt == '0))
        else $error("nonzero angles for an unused mount mode");
endmodule

/* test/tb_gimbal_pan_tilt_pointing.sv */
module tb_gimbal_pan_tilt_pointing import gpp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 3 * CORDIC_STAGES + 16;
    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_WORDS = 125;
    localparam int PHASES      = 14;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint  K_Q26  = 40752055;
    localparam longint  K_Q20  = 636751;
    localparam logic [31:0] PI_PH  = 32'h8000_0000;
    localparam logic [31:0] PI2_PH = 32'h4000_0000;

    typedef struct {
        t_pos pe, pn, pa;
        t_ang roll, pitch, yaw;
        t_pos te, tn, ta;
    } t_pose;

    typedef struct {
        t_ang pan;
        t_ang tilt;
    } t_aim;

    typedef struct {
        logic [2:0] mode;
        t_pose      w;
        bit         fixed;
        t_aim       aim;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_data;

    gpp_in_if  in_if ();
    gpp_out_if out_if ();

    gimbal_pan_tilt_pointing dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    t_aim       aim_q [$];
    t_row       rows [$];
    logic [2:0] cur_mode;
    int         errors;
    int         words_in;
    int         words_out;
    int         idle_cycles;
    bit         no_idle;
    int         rdy_stall;

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void sin_cos(input logic [31:0] ph, output longint c,
                                    output longint s);
        logic [31:0] t;
        bit     flip;
        longint x, y, z, n;
        t = ph + PI2_PH;
        flip = t[31];
        if (flip) begin
            ph = ph + PI_PH;
        end
        z = longint'(signed'(ph));
        x = K_Q26;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
                n = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_STEP[i];
            end else begin
                n = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_STEP[i];
            end
            x = n;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void vector(input longint x, input longint y,
                                   output logic [31:0] ang, output longint mag);
        longint n;
        ang = '0;
        mag = 0;
        if (x == 0 && y == 0) begin
            return;
        end
        if (x < 0) begin
            x = -x; y = -y; ang = PI_PH;
        end
        x = x <<< 20;
        y = y <<< 20;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y > 0) begin
                n = x + (y >>> i); y = y - (x >>> i); ang = ang + 32'(ATAN_STEP[i]);
            end else begin
                n = x - (y >>> i); y = y + (x >>> i); ang = ang - 32'(ATAN_STEP[i]);
            end
            x = n;
        end
        mag = (((x >>> 20) * K_Q20) + (64'sd1 <<< 19)) >>> 20;
    endfunction

    function automatic t_ang bearing(input longint y, input longint x);
        logic [31:0] a;
        logic [31:0] t;
        longint m;
        vector(x, y, a, m);
        t = a + (32'd1 << (31 - ANGLE_BITS));
        return t_ang'(t[31:32-ANGLE_BITS]);
    endfunction

    function automatic longint range_of(input longint a, input longint b);
        logic [31:0] ang;
        longint m;
        vector(a, b, ang, m);
        return m;
    endfunction

    function automatic longint rq(input longint v);
        return (v + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic t_aim predict_aim(input t_pose w, input logic [2:0] mode);
        t_aim   r;
        longint x, y, z, c, s, nx, ny, nz;
        x = (longint'(w.tn) - longint'(w.pn)) <<< EXT;
        y = (longint'(w.te) - longint'(w.pe)) <<< EXT;
        z = (longint'(w.ta) - longint'(w.pa)) <<< EXT;
        sin_cos({w.yaw, 16'h0}, c, s);
        nx = rq(c * x + s * y); ny = rq(c * y - s * x);
        x = nx; y = ny;
        sin_cos({w.pitch, 16'h0}, c, s);
        nx = rq(c * x + s * z); nz = rq(c * z - s * x);
        x = nx; z = nz;
        sin_cos({w.roll, 16'h0}, c, s);
        ny = rq(c * y - s * z); nz = rq(s * y + c * z);
        y = ny; z = nz;
        r.pan = '0;
        r.tilt = '0;
        case (mode)
            MODE_PITCH: begin
                r.tilt = bearing(x, -z);
            end
            MODE_ROLL: begin
                r.tilt = bearing(y, range_of(x, z));
            end
            MODE_NOSE_PAN: begin
                r.pan = bearing(y, x);
                r.tilt = bearing(range_of(x, y), -z);
            end
            MODE_NOSE_FOLD: begin
                r.pan = bearing(y, x < 0 ? -x : x);
                r.tilt = bearing(range_of(x, y), -z);
                if (x < 0) begin
                    r.pan = -r.pan; r.tilt = -r.tilt;
                end
            end
            MODE_SIDE: begin
                r.pan = bearing(x, y < 0 ? -y : y);
                r.tilt = bearing(range_of(x, y), -z);
                if (y < 0) begin
                    r.pan = -r.pan; r.tilt = -r.tilt;
                end
            end
            MODE_PITCH_ROLL: begin
                r.tilt = bearing(x, -z);
                r.pan = bearing(-y, range_of(x, z));
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report(input string what, input t_ang got, input t_ang want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic drain();
        while (aim_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_mode = m;
    endtask

    task automatic send_word(input t_pose w, input bit fixed, input t_aim aim);
        int gap;
        in_if.valid        <= 1'b1;
        in_if.plane_east   <= w.pe;
        in_if.plane_north  <= w.pn;
        in_if.plane_alt    <= w.pa;
        in_if.roll_angle   <= w.roll;
        in_if.pitch_angle  <= w.pitch;
        in_if.yaw_angle    <= w.yaw;
        in_if.target_east  <= w.te;
        in_if.target_north <= w.tn;
        in_if.target_alt   <= w.ta;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        aim_q.push_back(fixed ? aim : predict_aim(w, cur_mode));
        words_in++;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_pose mk(input int pe, pn, pa, r, p, yw, te, tn, ta);
        t_pose w;
        w.pe = t_pos'(pe); w.pn = t_pos'(pn); w.pa = t_pos'(pa);
        w.roll = t_ang'(r); w.pitch = t_ang'(p); w.yaw = t_ang'(yw);
        w.te = t_pos'(te); w.tn = t_pos'(tn); w.ta = t_pos'(ta);
        return w;
    endfunction

    function automatic void add_row(input logic [2:0] m, input t_pose w,
                                    input bit fixed, input int pan, input int tilt);
        t_row r;
        r.mode = m; r.w = w; r.fixed = fixed;
        r.aim.pan = t_ang'(pan); r.aim.tilt = t_ang'(tilt);
        rows.push_back(r);
    endfunction

    function automatic t_pose rand_pose();
        t_pose w;
        w.pe = t_pos'($urandom); w.pn = t_pos'($urandom); w.pa = t_pos'($urandom);
        w.roll = t_ang'($urandom); w.pitch = t_ang'($urandom); w.yaw = t_ang'($urandom);
        if ($urandom_range(0, 1)) begin
            w.te = t_pos'($urandom); w.tn = t_pos'($urandom); w.ta = t_pos'($urandom);
        end else begin
            w.te = w.pe + t_pos'($urandom_range(0, 4000)) - t_pos'(2000);
            w.tn = w.pn + t_pos'($urandom_range(0, 4000)) - t_pos'(2000);
            w.ta = w.pa - t_pos'($urandom_range(0, 3000));
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (in_if.valid && in_if.ready || out_if.valid && out_if.ready) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || rdy_stall == 0 && (no_idle || $urandom_range(0, 3) != 0)) begin
            out_if.ready <= 1'b1;
        end else begin
            if (rdy_stall == 0) begin
                rdy_stall = pick_gap();
            end
            out_if.ready <= (rdy_stall == 0);
            if (rdy_stall > 0) begin
                rdy_stall--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_aim want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            words_out++;
            if (aim_q.size() == 0) begin
                report("unexpected word, pan", out_if.pan_angle, '0);
            end else begin
                want = aim_q.pop_front();
                if (out_if.pan_angle !== want.pan) begin
                    report("pan_angle", out_if.pan_angle, want.pan);
                end
                if (out_if.tilt_angle !== want.tilt) begin
                    report("tilt_angle", out_if.tilt_angle, want.tilt);
                end
            end
        end
    end

    initial begin
        t_pose w;
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.plane_east <= '0; in_if.plane_north <= '0; in_if.plane_alt <= '0;
        in_if.roll_angle <= '0; in_if.pitch_angle <= '0; in_if.yaw_angle <= '0;
        in_if.target_east <= '0; in_if.target_north <= '0; in_if.target_alt <= '0;
        no_idle = 1'b0;
        words_in = 0;
        cur_mode = MODE_SIDE;

        add_row(MODE_SIDE, mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(MODE_SIDE, mk(-8388608, -8388608, -8388608, 0, 0, 0,
                              8388607, 8388607, 8388607), 0, 0, 0);
        add_row(MODE_SIDE, mk(8388607, 8388607, 8388607, -32768, 32767, -32768,
                              -8388608, -8388608, -8388608), 0, 0, 0);
        add_row(MODE_SIDE, mk(5, 5, 5, 32767, -32768, 32767, 5, 5, 5), 1, 0, 0);
        add_row(MODE_SIDE, mk(0, 0, 100, 0, 16384, 0, -300, 50, 0), 0, 0, 0);
        add_row(MODE_PITCH, mk(0, 0, 500, 0, 0, 0, 0, 1000, 0), 0, 0, 0);
        add_row(MODE_PITCH, mk(0, 0, 500, 0, -16384, 0, 0, -1000, 900), 0, 0, 0);
        add_row(MODE_ROLL, mk(0, 0, 500, 8192, 0, 0, 700, 0, 0), 0, 0, 0);
        add_row(MODE_ROLL, mk(1, 2, 3, 0, 0, 0, 1, 2, 3), 1, 0, 0);
        add_row(MODE_NOSE_PAN, mk(0, 0, 500, 0, 0, 0, 0, -1000, 0), 0, 0, 0);
        add_row(MODE_NOSE_PAN, mk(0, 0, 500, 0, 0, 16384, 400, 400, 0), 0, 0, 0);
        add_row(MODE_NOSE_FOLD, mk(0, 0, 500, 0, 0, 0, 300, -1000, 0), 0, 0, 0);
        add_row(MODE_NOSE_FOLD, mk(0, 0, 500, 0, 0, 0, -300, 1000, 0), 0, 0, 0);
        add_row(MODE_SIDE, mk(0, 0, 500, 0, 0, 0, -800, 200, 0), 0, 0, 0);
        add_row(MODE_PITCH_ROLL, mk(0, 0, 500, 0, 0, 0, 300, 200, 0), 0, 0, 0);
        add_row(MODE_PITCH_ROLL, mk(0, 0, 0, -32768, -32768, -32768,
                                    -1, 1, -1), 0, 0, 0);
        add_row(MODE_SPARE_6, mk(0, 0, 500, 100, 200, 300, 900, 800, 0), 1, 0, 0);
        add_row(MODE_SPARE_7, mk(-8388608, 8388607, 0, 1, 2, 3,
                                 8388607, -8388608, 7), 1, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].mode != cur_mode) begin
                in_if.valid <= 1'b0;
                set_mode(rows[k].mode);
            end
            send_word(rows[k].w, rows[k].fixed, rows[k].aim);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            in_if.valid <= 1'b0;
            set_mode(ph < 8 ? 3'(ph) : 3'($urandom_range(0, 7)));
            no_idle = (ph % 4 == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w = rand_pose();
                send_word(w, 1'b0, '{default: '0});
            end
        end
        in_if.valid <= 1'b0;
        no_idle = 1'b0;

        drain();
        $display("Ran %0d directed and %0d random words over all eight mount modes,",
                 rows.size(), words_in - rows.size());
        $display("%0d results checked, %0d field errors", words_out, errors);
        if (errors == 0 && aim_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/gpp_pkg.sv
rtl/gpp_in_if.sv
rtl/gpp_out_if.sv
rtl/gpp_rot_cell.sv
rtl/gpp_vec_cell.sv
rtl/gpp_rotate.sv
rtl/gimbal_pan_tilt_pointing.sv
test/tb_gimbal_pan_tilt_pointing.sv
